[rtl/assert_macros.svh]
// Assertion macros shared by the Sobel direction NMS block.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

[rtl/sdn_pkg.sv]
// Package for the Sobel direction NMS block: types and fixed constants.
// Depends on nothing.
package sdn_pkg;
    localparam logic [25:0] SLOPE_LO = 26'd6949350;
    localparam logic [25:0] SLOPE_HI = 26'd40503782;
    localparam logic [12:0] THRESH_CAP = 13'd4096;
    localparam logic [1:0] ADDR_WIDTH = 2'd0;
    localparam logic [1:0] ADDR_HEIGHT = 2'd1;
    localparam logic [1:0] ADDR_LOW = 2'd2;
    localparam logic [1:0] ADDR_HIGH = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CALC  = 4'b0010,
        ST_SQRT  = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic calc;
        logic sqrt_step;
        logic finish;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic skip;
        logic sqrt_done;
    } t_status;
endpackage

[rtl/sdn_ctrl.sv]
// Controller state machine of the Sobel direction NMS block.
// Depends on sdn_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sdn_ctrl
    import sdn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_out_busy,
    input  t_status i_status,
    output logic    o_stall,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = i_status.skip ? ST_IDLE : ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = !i_status.sqrt_done;
                if (i_status.sqrt_done) n_state = ST_FIN;
            end
            ST_FIN: begin
                // The result waits here while the previous word is still held.
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_stall = !(r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    `ASSERT_IMPL(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `ASSERT_NEXT(a_load_calc, i_clk, i_rst_n, o_cmd.load, r_state == ST_CALC)
    `ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n, r_state != ST_IDLE, o_stall)
    `ASSERT_IMPL(a_fin_wait, i_clk, i_rst_n, i_out_busy, !o_cmd.finish)
endmodule

[rtl/sdn_datapath.sv]
// Datapath of the Sobel direction NMS block: line memories, window, sqrt, NMS.
// Depends on sdn_pkg.
module sdn_datapath
    import sdn_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_gray,
    input  logic        i_flush,
    input  logic        i_geom_wr,
    input  logic [11:0] i_width,
    input  logic [15:0] i_height,
    input  logic [12:0] i_low,
    input  logic [12:0] i_high,
    input  logic        i_out_stall,
    output t_status     o_status,
    output logic        o_out_busy,
    output logic        o_valid,
    output logic [10:0] o_mag,
    output logic [1:0]  o_dir,
    output logic [1:0]  o_class,
    output logic        o_last
);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);

    logic [7:0]  r_gmid [MAX_WIDTH];
    logic [7:0]  r_gtop [MAX_WIDTH];
    logic [10:0] r_mmid [MAX_WIDTH];
    logic [10:0] r_mtop [MAX_WIDTH];
    logic [1:0]  r_dmem [MAX_WIDTH];

    logic [CW-1:0] r_col;
    logic [16:0]   r_row;
    logic [10:0]   r_win [13];

    // Effective geometry.
    logic [CW-1:0] w_w;
    logic [16:0]   w_h;
    always_comb begin
        if (i_width < 12'd3) w_w = CW'(3);
        else if (32'(i_width) > MAX_WIDTH) w_w = CW'(MAX_WIDTH);
        else w_w = CW'(i_width);
        w_h = (i_height < 16'd3) ? 17'd3 : {1'b0, i_height};
    end

    // Latched item context.
    logic [7:0]    r_pix;
    logic [CW-1:0] r_x;
    logic [16:0]   r_y;
    logic          r_skip;
    logic [7:0]    r_top, r_mid;
    logic [10:0]   r_mt, r_mm;
    logic [1:0]    r_dn;
    logic signed [17:0] r_cs;
    logic          r_in_s, r_in_n, r_emit;
    logic          r_last;

    // Position of this item and its delayed positions.
    logic [CW-1:0] w_x;
    logic          w_drain, w_skip;
    logic signed [17:0] w_ys, w_cs, w_yn, w_cn, w_iw, w_ih;
    always_comb begin
        w_x = (r_col >= w_w) ? '0 : r_col;
        w_drain = r_row >= w_h;
        w_skip = !w_drain && i_flush && r_row == 17'd0 && w_x == '0;
        w_iw = 18'(w_w);
        w_ih = 18'(w_h);
        if (w_x != '0) begin
            w_ys = 18'(r_row) - 18'sd1; w_cs = 18'(w_x) - 18'sd1;
        end else begin
            w_ys = 18'(r_row) - 18'sd2; w_cs = w_iw - 18'sd1;
        end
        if (w_cs >= 18'sd1) begin
            w_yn = w_ys - 18'sd1; w_cn = w_cs - 18'sd1;
        end else begin
            w_yn = w_ys - 18'sd2; w_cn = w_iw - 18'sd1;
        end
    end

    // Gradient from the window.
    logic [21:0] r_rem, r_root, r_bit;
    logic [1:0]  r_dir;
    logic signed [12:0] w_gx, w_gy;
    always_comb begin
        w_gx = -13'(r_win[0]) + 13'(r_top) - 13'(r_win[1] << 1) + 13'({r_mid, 1'b0})
               - 13'(r_win[2]) + 13'(r_pix);
        w_gy = 13'(r_win[0]) + 13'(r_win[3] << 1) + 13'(r_top) - 13'(r_win[2])
               - 13'(r_win[5] << 1) - 13'(r_pix);
    end

    // Sector by slope comparisons.
    function automatic logic [1:0] sector(input logic signed [12:0] gx,
                                          input logic signed [12:0] gy);
        logic signed [12:0] x, y;
        logic [11:0] ax;
        logic [37:0] sy, p1, p2;
        x = gx; y = gy;
        if (y < 0) begin x = -x; y = -y; end
        ax = x[12] ? 12'(-x) : 12'(x);
        sy = {14'(y), 24'd0};
        p1 = 38'(ax) * 38'(SLOPE_LO);
        p2 = 38'(ax) * 38'(SLOPE_HI);
        if (y == 0) return 2'd0;
        if (!x[12]) begin
            if (sy < p1) return 2'd0;
            if (sy < p2) return 2'd1;
            return 2'd2;
        end
        if (sy <= p1) return 2'd0;
        if (sy <= p2) return 2'd3;
        return 2'd2;
    endfunction

    assign o_status.skip = r_skip;
    assign o_status.sqrt_done = r_bit == '0;
    assign o_out_busy = o_valid && i_out_stall;

    // Thresholds.
    logic [12:0] w_lo, w_hi, w_a, w_b;
    always_comb begin
        w_a = (i_low > THRESH_CAP) ? THRESH_CAP : i_low;
        w_b = (i_high > THRESH_CAP) ? THRESH_CAP : i_high;
        w_lo = (w_a > w_b) ? w_b : w_a;
        w_hi = (w_a > w_b) ? w_a : w_b;
    end

    // Suppression uses the sector delayed in the window, not the one just read.
    logic [21:0] w_tr;
    logic [10:0] w_m1, w_m2, w_res, w_mag;
    logic [1:0]  w_dir;
    always_comb begin
        w_tr = r_root + r_bit;
        w_mag = r_in_s ? r_root[10:0] : 11'd0;
        w_dir = r_in_s ? r_dir : 2'd0;
        case (r_win[12][1:0])
            2'd0: begin w_m1 = r_win[7]; w_m2 = r_mm; end
            2'd1: begin w_m1 = r_mt; w_m2 = r_win[8]; end
            2'd2: begin w_m1 = r_win[9]; w_m2 = r_win[11]; end
            default: begin w_m1 = r_win[6]; w_m2 = w_mag; end
        endcase
        w_res = (r_win[10] >= w_m1 && r_win[10] >= w_m2) ? r_win[10] : 11'd0;
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_top <= r_gtop[w_x[AW-1:0]];
            r_mid <= r_gmid[w_x[AW-1:0]];
            r_mt <= r_mtop[w_cs[AW-1:0]];
            r_mm <= r_mmid[w_cs[AW-1:0]];
            r_dn <= r_dmem[w_cs[AW-1:0]];
        end
        if (i_cmd.calc && !r_skip) begin
            r_gtop[r_x[AW-1:0]] <= r_mid;
            r_gmid[r_x[AW-1:0]] <= r_pix;
        end
        if (i_cmd.finish) begin
            r_mtop[r_cs[AW-1:0]] <= r_mm;
            r_mmid[r_cs[AW-1:0]] <= w_mag;
            r_dmem[r_cs[AW-1:0]] <= w_dir;
        end
    end

    // Item load and sqrt iteration.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix <= (w_drain || i_flush) ? 8'd0 : i_gray;
            r_x <= w_x; r_y <= r_row; r_skip <= w_skip;
            r_cs <= w_cs;
            r_in_s <= w_ys >= 18'sd1 && w_ys <= w_ih - 18'sd2 &&
                      w_cs >= 18'sd1 && w_cs <= w_iw - 18'sd2;
            r_in_n <= w_yn >= 18'sd1 && w_yn <= w_ih - 18'sd2 &&
                      w_cn >= 18'sd1 && w_cn <= w_iw - 18'sd2;
            r_emit <= !w_yn[17];
            r_last <= w_yn == w_ih - 18'sd1 && w_cn == w_iw - 18'sd1;
        end
        if (i_cmd.calc) begin
            r_rem <= 22'(w_gx * w_gx) + 22'(w_gy * w_gy);
            r_root <= '0;
            r_bit <= 22'h100000;
            r_dir <= sector(w_gx, w_gy);
        end
        if (i_cmd.sqrt_step) begin
            if (r_rem >= w_tr) begin
                r_rem <= r_rem - w_tr;
                r_root <= (r_root >> 1) + r_bit;
            end else r_root <= r_root >> 1;
            r_bit <= r_bit >> 2;
        end
    end

    // Counters, window and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0; r_row <= '0; o_valid <= 1'b0;
            for (int k = 0; k < 13; k++) r_win[k] <= '0;
        end else begin
            if (o_valid && !i_out_stall) o_valid <= 1'b0;
            if (i_geom_wr) begin
                r_col <= '0; r_row <= '0;
            end else if (i_cmd.calc && !r_skip) begin
                r_win[0] <= r_win[3]; r_win[1] <= r_win[4]; r_win[2] <= r_win[5];
                r_win[3] <= 11'(r_top); r_win[4] <= 11'(r_mid); r_win[5] <= 11'(r_pix);
                if (r_x + 1'b1 >= w_w) begin
                    r_col <= '0; r_row <= r_y + 17'd1;
                end else begin
                    r_col <= r_x + 1'b1; r_row <= r_y;
                end
            end
            if (i_cmd.finish) begin
                r_win[6] <= r_win[9]; r_win[7] <= r_win[10]; r_win[8] <= r_win[11];
                r_win[9] <= r_mt; r_win[10] <= r_mm; r_win[11] <= w_mag;
                r_win[12] <= {9'd0, r_dn};
                if (r_emit) begin
                    o_valid <= 1'b1;
                    o_mag <= r_in_n ? w_res : 11'd0;
                    o_dir <= r_in_n ? r_win[12][1:0] : 2'd0;
                    o_class <= !r_in_n ? ((13'd0 >= w_hi) ? 2'd2 : (13'd0 >= w_lo) ? 2'd1 : 2'd0)
                             : ((13'(w_res) >= w_hi) ? 2'd2 : (13'(w_res) >= w_lo) ? 2'd1 : 2'd0);
                    o_last <= r_last;
                    if (r_last) begin r_col <= '0; r_row <= '0; end
                end
            end
        end
    end
endmodule

[rtl/sobel_direction_nms_core.sv]
// Sobel gradient, direction sector and non-maximum suppression stream block.
// Channels: pixel input (i_valid/o_stall) and result output (o_valid/i_stall),
// one word each; an APB port sets width, height and two thresholds.
// A pixel word goes through these steps in order: accept it and read the line
// memories, form the gradient, 11 steps of the square-root unit, a check that
// sees the root finish, then suppress and register the result once the output
// is free. The input stalls until the word is finished.
// A result word appears 2*width+2 pixel words after its pixel; the first
// 2*width+2 words of a frame give no result, and flush words drain the tail.
// The result register holds its word while i_stall is high; one more pixel
// is taken meanwhile, and its result waits in the last step until that
// word leaves, so the input stalls.
// Reset clears the counters, window and result valid flag; line memories
// are not cleared, and their stale contents reach only border results, which are zero.
// Writing width or height restarts the frame and drops pending results.
module sobel_direction_nms_core
    import sdn_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_gray_level,
    input  logic        i_flush,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_suppressed_magnitude,
    output logic [1:0]  o_direction_sector,
    output logic [1:0]  o_edge_class,
    output logic        o_last_of_frame
);
    logic [11:0] r_width;
    logic [15:0] r_height;
    logic [12:0] r_low, r_high;
    logic w_wr;
    t_cmd w_cmd;
    t_status w_status;
    logic w_busy;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;

    // Register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 12'd640; r_height <= 16'd480; r_low <= 13'd50; r_high <= 13'd150;
        end else if (w_wr && paddr[1:0] == 2'b00) begin
            case (paddr[3:2])
                ADDR_WIDTH:  r_width <= pwdata[11:0];
                ADDR_HEIGHT: r_height <= pwdata[15:0];
                ADDR_LOW:    r_low <= pwdata[12:0];
                ADDR_HIGH:   r_high <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (paddr[3:2])
            ADDR_WIDTH:  prdata = {20'd0, r_width};
            ADDR_HEIGHT: prdata = {16'd0, r_height};
            ADDR_LOW:    prdata = {19'd0, r_low};
            ADDR_HIGH:   prdata = {19'd0, r_high};
            default:     prdata = '0;
        endcase
    end

    sdn_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_out_busy(w_busy),
        .i_status(w_status), .o_stall(o_stall), .o_cmd(w_cmd)
    );

    sdn_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_gray(i_gray_level),
        .i_flush(i_flush),
        .i_geom_wr(w_wr && paddr[1:0] == 2'b00 &&
                   (paddr[3:2] == ADDR_WIDTH || paddr[3:2] == ADDR_HEIGHT)),
        .i_width(r_width), .i_height(r_height), .i_low(r_low), .i_high(r_high),
        .i_out_stall(i_stall), .o_status(w_status), .o_out_busy(w_busy),
        .o_valid(o_valid), .o_mag(o_suppressed_magnitude), .o_dir(o_direction_sector),
        .o_class(o_edge_class), .o_last(o_last_of_frame)
    );
endmodule
